// ----- hw/rtl/ptrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptrd_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int CNT_W         = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int LVL_CMP_W     = 7;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [1:0] ST_ADDED     = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DISPATCH  = 2'd2;
  localparam logic [1:0] ST_IDLE_TICK = 2'd3;

  // One input transaction after classification.
  typedef struct packed {
    logic        is_tick;
    logic [15:0] task_period;
    logic [15:0] start_delay;
    logic [3:0]  running_level;
  } q_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/periodic_task_release_dispatcher_top.sv -----
// An add passes through the input queue, then its result enters the output
// register; a tick passes through the queue, latches its eligible slots and
// scans up from slot 0. The scan visits one slot per cycle, waiting on an
// eligible slot while the output is stalled. Adds sustain one per cycle while
// the output is not stalled; a two-entry queue accepts during a scan until full.
// Reset clears slot valid and ready flags and all control, not period or delay.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_release_dispatcher_top import ptrd_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [15:0] task_period_i,
  input  wire logic [15:0] start_delay_i,
  input  wire logic [3:0]  running_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       slot_o,
  output logic             last_o
);

  logic    head_valid;
  q_item_t head;
  logic    pop;

  ptrd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .task_period_i   (task_period_i),
    .start_delay_i   (start_delay_i),
    .running_level_i (running_level_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  ptrd_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ptrd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptrd_front import ptrd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [15:0] task_period_i,
  input  wire logic [15:0] start_delay_i,
  input  wire logic [3:0]  running_level_i,
  output logic             head_valid_o,
  output q_item_t          head_o,
  input  wire logic        pop_i
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  q_item_t               mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [PtrW:0]         count_q;
  logic                  push;
  q_item_t               item;

  assign in_ready_o   = (count_q != (PtrW+1)'(QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    item.is_tick       = (mode_i == MODE_TICK);
    item.task_period   = task_period_i;
    item.start_delay   = start_delay_i;
    item.running_level = running_level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (push && !pop_i) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (!push && pop_i) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ptrd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptrd_back import ptrd_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  wire q_item_t     head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       slot_o,
  output logic             last_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [0:0] {S_IDLE, S_SCAN} state_e;

  state_e                 state_q;
  logic [NUM_SLOTS-1:0]   valid_q, ready_q, oneshot_q, elig_q;
  logic [15:0]            period_q [NUM_SLOTS];
  logic [15:0]            delay_q  [NUM_SLOTS];
  logic [IdxW-1:0]        scan_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   out_valid_q, last_q;
  logic [1:0]             status_q;
  logic [2:0]             slot_q;

  logic                   out_free, free_found, add_we, tick_en, out_load;
  logic [IdxW-1:0]        free_idx;
  logic [NUM_SLOTS-1:0]   ready_tick, lvl_ok, elig_tick, rest;
  logic [15:0]            delay_tick [NUM_SLOTS];
  logic                   scan_hit, scan_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == S_IDLE) && head_valid_i && out_free;
  assign add_we   = pop_o && !head_i.is_tick && free_found;
  assign tick_en  = pop_o && head_i.is_tick;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // Per-slot timer update; each slot is an independent lane.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
    always_comb begin
      lvl_ok[g]     = (LVL_CMP_W'(g) < LVL_CMP_W'(head_i.running_level));
      ready_tick[g] = ready_q[g] || (valid_q[g] && (delay_q[g] == 16'd0));
      if (delay_q[g] != 16'd0) begin
        delay_tick[g] = delay_q[g] - 16'd1;
      end else if (period_q[g] != 16'd0) begin
        delay_tick[g] = period_q[g] - 16'd1;
      end else begin
        delay_tick[g] = 16'd0;
      end
    end
  end

  assign elig_tick = valid_q & ready_tick & lvl_ok;
  assign scan_hit  = elig_q[scan_q];
  assign rest      = elig_q & ~(NUM_SLOTS'(1) << scan_q);
  // The scan ends at the dispatch cap or when no eligible slot remains above.
  assign scan_last = (cnt_q == CNT_W'(MAX_RESULTS - 1)) || (rest == '0);
  // A new transaction enters the output register on this cycle.
  assign out_load  = (pop_o && (!head_i.is_tick || (elig_tick == '0))) ||
                     ((state_q == S_SCAN) && scan_hit && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      ready_q     <= '0;
      elig_q      <= '0;
      scan_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      slot_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (!head_i.is_tick) begin
              last_q <= 1'b1;
              if (free_found) begin
                valid_q[free_idx] <= 1'b1;
                ready_q[free_idx] <= 1'b0;
                status_q          <= ST_ADDED;
                slot_q            <= 3'(free_idx);
              end else begin
                status_q <= ST_FULL;
                slot_q   <= '0;
              end
            end else begin
              ready_q <= ready_tick;
              if (elig_tick == '0) begin
                status_q <= ST_IDLE_TICK;
                slot_q   <= '0;
                last_q   <= 1'b1;
              end else begin
                elig_q  <= elig_tick;
                scan_q  <= '0;
                cnt_q   <= '0;
                state_q <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (!scan_hit) begin
            scan_q <= scan_q + IdxW'(1);
          end else if (out_free) begin
            status_q        <= ST_DISPATCH;
            slot_q          <= 3'(scan_q);
            last_q          <= scan_last;
            ready_q[scan_q] <= 1'b0;
            elig_q[scan_q]  <= 1'b0;
            if (oneshot_q[scan_q]) begin
              valid_q[scan_q] <= 1'b0;
            end
            cnt_q <= cnt_q + CNT_W'(1);
            if (scan_last) begin
              state_q <= S_IDLE;
            end else begin
              scan_q <= scan_q + IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      period_q[free_idx]  <= head_i.task_period;
      delay_q[free_idx]   <= head_i.start_delay;
      oneshot_q[free_idx] <= (head_i.task_period == 16'd0);
    end else if (tick_en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (valid_q[i]) begin
          delay_q[i] <= delay_tick[i];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign last_o      = last_q;

  a_scan_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (elig_q != '0))
    else $error("scan active with no eligible slot");

  a_scan_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_hit && out_free && scan_last) |=> (state_q == S_IDLE))
    else $error("scan did not finish after last dispatch");

  a_no_pop_while_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !pop_o)
    else $error("queue popped during dispatch scan");

  a_dispatch_was_eligible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_hit && out_free) |-> (valid_q[scan_q] && ready_q[scan_q]))
    else $error("dispatch of a slot that is not valid and ready");

endmodule

`default_nettype wire

// ----- test/periodic_task_release_dispatcher_top_tb.sv -----
`timescale 1ns / 1ps

module periodic_task_release_dispatcher_top_tb;
  import ptrd_pkg::*;

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 400;
  localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 4;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic       last;
  } release_t;

  // Shadow copy of the task table plus the releases it predicts.
  class dispatch_table_model;
    bit          slot_used[NUM_SLOTS];
    bit          slot_due[NUM_SLOTS];
    logic [15:0] slot_period[NUM_SLOTS];
    logic [15:0] slot_count[NUM_SLOTS];
    release_t    pending_releases[$];
    int          mismatches;
    int          n_added;
    int          n_full;
    int          n_dispatched;
    int          n_idle;

    function int periodic_tasks();
      int i;
      int cnt;
      cnt = 0;
      for (i = 0; i < NUM_SLOTS; i++)
        if (slot_used[i] && slot_period[i] != 16'd0) cnt++;
      return cnt;
    endfunction

    function bit table_full();
      int i;
      for (i = 0; i < NUM_SLOTS; i++)
        if (!slot_used[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void predict_releases(logic mode, logic [15:0] period, logic [15:0] delay,
                                   logic [3:0] level);
      int i;
      int lim;
      int fired;
      bit placed;
      release_t r;
      fired  = 0;
      placed = 1'b0;
      if (mode == MODE_ADD) begin
        for (i = 0; i < NUM_SLOTS && !placed; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]   = 1'b1;
            slot_period[i] = period;
            slot_count[i]  = delay;
            slot_due[i]    = 1'b0;
            r = '{status: ST_ADDED, slot: 3'(i), last: 1'b1};
            pending_releases.push_back(r);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          r = '{status: ST_FULL, slot: 3'd0, last: 1'b1};
          pending_releases.push_back(r);
        end
      end else begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_count[i] != 16'd0) begin
              slot_count[i] = slot_count[i] - 16'd1;
            end else begin
              slot_due[i]   = 1'b1;
              slot_count[i] = (slot_period[i] != 16'd0) ? slot_period[i] - 16'd1 : 16'd0;
            end
          end
        end
        // Levels above the table size let every slot dispatch.
        lim = (int'(level) > NUM_SLOTS) ? NUM_SLOTS : int'(level);
        for (i = 0; i < lim && fired < MAX_RESULTS; i++) begin
          if (slot_used[i] && slot_due[i]) begin
            slot_due[i] = 1'b0;
            if (slot_period[i] == 16'd0) slot_used[i] = 1'b0;
            r = '{status: ST_DISPATCH, slot: 3'(i), last: 1'b0};
            pending_releases.push_back(r);
            fired++;
          end
        end
        if (fired == 0) begin
          r = '{status: ST_IDLE_TICK, slot: 3'd0, last: 1'b1};
          pending_releases.push_back(r);
        end else begin
          pending_releases[pending_releases.size() - 1].last = 1'b1;
        end
      end
    endfunction

    function void check_release(release_t got);
      release_t want;
      if (pending_releases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d slot=%0d last=%0d",
                   $realtime, got.status, got.slot, got.last);
        return;
      end
      want = pending_releases.pop_front();
      if (got.status !== want.status || got.slot !== want.slot || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch expected status=%0d slot=%0d last=%0d, got %0d/%0d/%0d",
                   $realtime, want.status, want.slot, want.last,
                   got.status, got.slot, got.last);
      end
      case (want.status)
        ST_ADDED:    n_added++;
        ST_FULL:     n_full++;
        ST_DISPATCH: n_dispatched++;
        default:     n_idle++;
      endcase
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [15:0] task_period;
  logic [15:0] start_delay;
  logic [3:0]  running_level;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [2:0]  slot;
  logic        last;

  dispatch_table_model table_model = new();
  bit quiet_phase;
  int idle_cycles;

  periodic_task_release_dispatcher_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .task_period_i   (task_period),
    .start_delay_i   (start_delay),
    .running_level_i (running_level),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .slot_o          (slot),
    .last_o          (last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function int draw_wait();
    return quiet_phase ? 0 : $urandom_range(0, 13);
  endfunction

  // Entered and left right after a rising edge.
  task automatic send_request(logic m, logic [15:0] period, logic [15:0] delay,
                              logic [3:0] level);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    task_period   <= period;
    start_delay   <= delay;
    running_level <= level;
    do @(negedge clk_i); while (!in_ready);
    table_model.predict_releases(m, period, delay, level);
    @(posedge clk_i);
  endtask

  task automatic wait_for_releases();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (table_model.pending_releases.size() != 0);
  endtask

  // Outputs and handshakes are sampled at the falling edge, away from the
  // rising edge at which both sides update.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready)
        table_model.check_release('{status: status, slot: slot, last: last});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(negedge clk_i); while (!out_valid);
      @(posedge clk_i);
    end
  end

  initial begin
    int n;
    logic [3:0] lvl;
    rst_ni        <= 1'b0;
    in_valid      <= 1'b0;
    mode          <= MODE_ADD;
    task_period   <= '0;
    start_delay   <= '0;
    running_level <= '0;
    quiet_phase   = 1'b0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slot 0 takes the largest period and delay and stays busy for the run.
    send_request(MODE_ADD, 16'hFFFF, 16'hFFFF, 4'd0);
    send_request(MODE_ADD, 16'd0, 16'd0, 4'd15);
    send_request(MODE_ADD, 16'd3, 16'd1, 4'd8);
    send_request(MODE_ADD, 16'd0, 16'd2, 4'd8);
    for (n = 0; n < 4; n++)
      send_request(MODE_ADD, 16'd0, 16'(n), 4'(n));
    send_request(MODE_ADD, 16'h5A5A, 16'hA5A5, 4'd8);
    // Nothing lies below level 0, so this tick dispatches nothing.
    send_request(MODE_TICK, 16'h0000, 16'h0000, 4'd0);
    send_request(MODE_TICK, 16'hFFFF, 16'hFFFF, 4'd2);
    send_request(MODE_TICK, 16'h1234, 16'h8765, 4'd15);
    for (n = 0; n < 5; n++)
      send_request(MODE_TICK, 16'($urandom), 16'($urandom), 4'd8);
    send_request(MODE_ADD, 16'd0, 16'd0, 4'd9);
    send_request(MODE_TICK, 16'd0, 16'd0, 4'd12);
    wait_for_releases();

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) quiet_phase = (n == 100) || ($urandom_range(0, 4) == 0);
      if (n == 200) wait_for_releases();
      if ($urandom_range(0, 9) < 4) begin
        if (table_model.table_full() && $urandom_range(0, 1) == 0)
          send_request(MODE_ADD, 16'($urandom), 16'($urandom), 4'($urandom));
        else if (table_model.periodic_tasks() < 4 && $urandom_range(0, 2) == 0)
          send_request(MODE_ADD, 16'($urandom_range(1, 8)), 16'($urandom_range(0, 8)),
                       4'($urandom));
        else
          send_request(MODE_ADD, 16'd0, 16'($urandom_range(0, 6)), 4'($urandom));
      end else begin
        lvl = ($urandom_range(0, 1) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
        send_request(MODE_TICK, 16'($urandom), 16'($urandom), lvl);
      end
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    while (table_model.pending_releases.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Results seen: %0d adds, %0d table full, %0d dispatches, %0d idle ticks",
             table_model.n_added, table_model.n_full, table_model.n_dispatched,
             table_model.n_idle);
    $display("Mismatches: %0d, results still outstanding: %0d",
             table_model.mismatches, table_model.pending_releases.size());
    if (table_model.mismatches == 0 && table_model.pending_releases.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
